@@ design/rx_block_fifo_framer_top_macros.svh @@
// Assertion macros shared by the framer modules; clk and rst come from the using scope.
`ifndef RX_BLOCK_FIFO_FRAMER_TOP_MACROS_SVH
`define RX_BLOCK_FIFO_FRAMER_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define RBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rbf_pkg.sv @@
package rbf_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 4096;

  localparam logic [2:0] KIND_RX    = 3'd0;
  localparam logic [2:0] KIND_TICK  = 3'd1;
  localparam logic [2:0] KIND_DRAIN = 3'd2;
  localparam logic [2:0] KIND_HOST  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FLUSH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_GAP    = 2'd2;
  localparam int CFG_DATA_W = 12;

  localparam logic [7:0]  CR_CODE   = 8'h0D;
  localparam logic [7:0]  LF_CODE   = 8'h0A;
  localparam logic [11:0] COUNT_MAX = 12'hFFF;
  localparam logic [7:0]  IDLE_MAX  = 8'hFF;

  localparam logic [11:0] FLUSH_COUNT_RESET = 12'd128;
  localparam logic [7:0]  IDLE_FLUSH_RESET  = 8'd20;
  localparam logic [7:0]  RESP_GAP_RESET    = 8'd12;

  typedef struct packed {
    logic        out_valid;
    logic        accepted;
    logic        block_ready;
    logic        waiting;
    logic [11:0] fill_level;
  } res_t;

endpackage

@@ design/rbf_ram.sv @@
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rbf_ctrl.sv @@
module rbf_ctrl #(
  parameter int FIFO_DEPTH = rbf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [2:0]                          kind,
  input  logic [7:0]                          data_byte,
  input  logic                                cfg_we,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                ram_we,
  output logic [$clog2(FIFO_DEPTH)-1:0]       ram_waddr,
  output logic [7:0]                          ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(FIFO_DEPTH)-1:0]       ram_raddr,
  output rbf_pkg::res_t                       res
);
  import rbf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int LVL_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [LVL_W-1:0] DEPTH_LVL = LVL_W'(FIFO_DEPTH);

  logic [11:0]      flush_count;
  logic [7:0]       idle_flush;
  logic [7:0]       resp_gap;

  logic [PTR_W-1:0] wp, wp_next, rp, rp_next;
  logic             blk, blk_next, await_flag, await_next;
  logic [11:0]      cnt, cnt_next;
  logic [7:0]       idle, idle_next;

  logic [PTR_W-1:0] wp_inc, wp_inc2, rp_inc;
  logic             empty, full, pend;
  logic             rd_valid, acc;
  logic [LVL_W-1:0] wp_ext, rp_ext, lvl;

  always_comb begin
    wp_inc  = (wp == LAST_SLOT) ? '0 : wp + 1'b1;
    wp_inc2 = (wp_inc == LAST_SLOT) ? '0 : wp_inc + 1'b1;
    rp_inc  = (rp == LAST_SLOT) ? '0 : rp + 1'b1;
    empty   = (wp == rp);
    full    = (wp_inc == rp);
    pend    = blk || (!empty && (idle > idle_flush));

    wp_next    = wp;
    rp_next    = rp;
    blk_next   = blk;
    await_next = await_flag;
    cnt_next   = cnt;
    idle_next  = idle;
    rd_valid   = 1'b0;
    acc        = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;

    unique case (kind)
      KIND_RX: begin
        if (!full) begin
          ram_we     = fire;
          wp_next    = wp_inc;
          cnt_next   = (cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;
          await_next = 1'b1;
          idle_next  = '0;
          acc        = 1'b1;
          if (data_byte == CR_CODE || data_byte == LF_CODE || cnt_next >= flush_count ||
              wp_inc2 == rp) begin
            blk_next = 1'b1;
          end
        end else begin
          blk_next = 1'b1;
        end
      end
      KIND_TICK: begin
        idle_next = (idle < IDLE_MAX) ? idle + 1'b1 : idle;
      end
      KIND_DRAIN: begin
        blk_next = pend;
        if (pend) begin
          if (!empty) begin
            ram_re   = fire;
            rp_next  = rp_inc;
            rd_valid = 1'b1;
          end
          if (empty || wp == rp_inc) begin
            blk_next = 1'b0;
            cnt_next = '0;
          end
        end
      end
      KIND_HOST: begin
        await_next = 1'b1;
      end
      KIND_CLEAR: begin
        wp_next    = '0;
        rp_next    = '0;
        blk_next   = 1'b0;
        await_next = 1'b0;
        cnt_next   = '0;
        idle_next  = IDLE_MAX;
      end
      default: begin
      end
    endcase

    if (await_next && !blk_next && wp_next == rp_next && idle_next > resp_gap) begin
      await_next = 1'b0;
    end

    wp_ext = LVL_W'(wp_next);
    rp_ext = LVL_W'(rp_next);
    lvl    = (wp_ext >= rp_ext) ? wp_ext - rp_ext : DEPTH_LVL - rp_ext + wp_ext;

    res.out_valid   = rd_valid;
    res.accepted    = acc;
    res.block_ready = blk_next;
    res.waiting     = await_next;
    res.fill_level  = 12'(lvl);
  end

  assign ram_waddr = wp;
  assign ram_wdata = data_byte;
  assign ram_raddr = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      rp          <= '0;
      blk         <= 1'b0;
      await_flag  <= 1'b0;
      cnt         <= '0;
      idle        <= '0;
      flush_count <= FLUSH_COUNT_RESET;
      idle_flush  <= IDLE_FLUSH_RESET;
      resp_gap    <= RESP_GAP_RESET;
    end else begin
      if (fire) begin
        wp         <= wp_next;
        rp         <= rp_next;
        blk        <= blk_next;
        await_flag <= await_next;
        cnt        <= cnt_next;
        idle       <= idle_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLUSH_COUNT: flush_count <= cfg_data;
          CFG_IDLE_FLUSH:  idle_flush  <= cfg_data[7:0];
          CFG_RESP_GAP:    resp_gap    <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  `include "rx_block_fifo_framer_top_macros.svh"

  `RBF_ASSERT_NEXT(a_clear_pointers, fire && kind == KIND_CLEAR, wp == '0 && rp == '0 && idle == IDLE_MAX, "clear left pointers or idle count")
  `RBF_ASSERT_NEXT(a_refused_sets_block, fire && kind == KIND_RX && full, blk && $stable(wp), "refused byte changed FIFO or missed block flag")
  `RBF_ASSERT_NOW(a_no_mem_collision, ram_we && ram_re, 1'b0, "write and read issued together")
  `RBF_ASSERT_NEXT(a_drain_empty_clears, fire && kind == KIND_DRAIN && res.out_valid && res.fill_level == '0 && FIFO_DEPTH <= 4096, !blk && cnt == '0, "emptying drain kept block state")

endmodule

@@ design/rbf_out.sv @@
module rbf_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  rbf_pkg::res_t res_in,
  input  logic [7:0]    rdata,
  output logic          in_stall,
  output logic          res_valid,
  input  logic          res_stall,
  output rbf_pkg::res_t res_out,
  output logic [7:0]    out_byte
);
  import rbf_pkg::*;

  logic s1_valid;
  res_t s1_res;
  logic s1_move;

  assign s1_move  = s1_valid && (!res_valid || !res_stall);
  assign in_stall = s1_valid && res_valid && res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res <= res_in;
    end
    if (s1_move) begin
      res_out  <= s1_res;
      out_byte <= s1_res.out_valid ? rdata : 8'h00;
    end
  end

  `include "rx_block_fifo_framer_top_macros.svh"

  `RBF_ASSERT_NOW(a_byte_zero_when_idle, res_valid && !res_out.out_valid, out_byte == 8'h00, "released byte not zero without a drain")
  `RBF_ASSERT_NOW(a_no_accept_when_blocked, fire, !in_stall, "request taken while pipeline blocked")
  `RBF_ASSERT_NEXT(a_stalled_result_holds, res_valid && res_stall, res_valid && $stable(res_out) && $stable(out_byte), "stalled result changed")

endmodule

@@ design/rx_block_fifo_framer_top.sv @@
// An accepted request is registered in s1, then in the result register when res_stall allows.
// Throughput: one request per cycle while in_stall is low; the byte store takes one write or one read per cycle.
// A stalled result holds one request in flight behind it before in_stall rises.
// Reset (rst, synchronous): pointers, flags, counters and pipeline clear, config
// returns to defaults; the byte store is not cleared.
module rx_block_fifo_framer_top #(
  parameter int FIFO_DEPTH = rbf_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     kind,
  input  logic [7:0]                     data_byte,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           out_valid,
  output logic [7:0]                     out_byte,
  output logic                           accepted,
  output logic                           block_ready,
  output logic                           waiting,
  output logic [11:0]                    fill_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rbf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic             fire;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  res_t             res_c, res_o;

  assign fire      = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  rbf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rbf_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (kind),
    .data_byte (data_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res_c)
  );

  rbf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_in    (res_c),
    .rdata     (ram_rdata),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_out   (res_o),
    .out_byte  (out_byte)
  );

  assign out_valid   = res_o.out_valid;
  assign accepted    = res_o.accepted;
  assign block_ready = res_o.block_ready;
  assign waiting     = res_o.waiting;
  assign fill_level  = res_o.fill_level;

endmodule
